@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the tokenizer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define STT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define STT_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ hw/rtl/stt_pkg.sv @@
// types, token kind codes and byte classification for the source text tokenizer
package stt_pkg;

   // depth of the byte queue and the token queue, as address bits
   localparam int QUEUE_DEPTH_BITS = 2;
   // width of every position field on the result ports
   localparam int OUT_BITS = 24;
   localparam int KIND_BITS = 6;

   // token kinds
   localparam logic [KIND_BITS-1:0] K_INT_LIT = 6'd0, K_FLOAT_LIT = 6'd1;
   localparam logic [KIND_BITS-1:0] K_STRING_LIT = 6'd2, K_IDENT = 6'd3;
   localparam logic [KIND_BITS-1:0] K_KW_INT = 6'd4, K_KW_BOOLEAN = 6'd5;
   localparam logic [KIND_BITS-1:0] K_KW_STRING = 6'd6, K_KW_TRUE = 6'd7;
   localparam logic [KIND_BITS-1:0] K_KW_FALSE = 6'd8, K_KW_NULL = 6'd9;
   localparam logic [KIND_BITS-1:0] K_KW_IF = 6'd10, K_KW_ELSE = 6'd11;
   localparam logic [KIND_BITS-1:0] K_KW_WHILE = 6'd12, K_KW_VAR = 6'd13;
   localparam logic [KIND_BITS-1:0] K_KW_FN = 6'd14, K_KW_RETURN = 6'd15;
   localparam logic [KIND_BITS-1:0] K_AND = 6'd16, K_OR = 6'd17, K_NOT = 6'd18;
   localparam logic [KIND_BITS-1:0] K_PLUS = 6'd19, K_MINUS = 6'd20, K_ARROW = 6'd21;
   localparam logic [KIND_BITS-1:0] K_STAR = 6'd22, K_SLASH = 6'd23, K_PERCENT = 6'd24;
   localparam logic [KIND_BITS-1:0] K_EQ_EQ = 6'd25, K_ASSIGN = 6'd26, K_NOT_EQ = 6'd27;
   localparam logic [KIND_BITS-1:0] K_LESS_EQ = 6'd28, K_SHL = 6'd29, K_LESS = 6'd30;
   localparam logic [KIND_BITS-1:0] K_GREATER_EQ = 6'd31, K_SHR = 6'd32;
   localparam logic [KIND_BITS-1:0] K_GREATER = 6'd33, K_AMP = 6'd34, K_BAR = 6'd35;
   localparam logic [KIND_BITS-1:0] K_CARET = 6'd36, K_TILDE = 6'd37;
   localparam logic [KIND_BITS-1:0] K_LPAREN = 6'd38, K_RPAREN = 6'd39;
   localparam logic [KIND_BITS-1:0] K_LBRACE = 6'd40, K_RBRACE = 6'd41;
   localparam logic [KIND_BITS-1:0] K_LBRACKET = 6'd42, K_RBRACKET = 6'd43;
   localparam logic [KIND_BITS-1:0] K_SEMI = 6'd44, K_COMMA = 6'd45, K_DOT = 6'd46;
   localparam logic [KIND_BITS-1:0] K_COLON = 6'd47, K_QUESTION = 6'd48;
   localparam logic [KIND_BITS-1:0] K_UNKNOWN = 6'd49, K_UNTERM = 6'd50;

   // character classes of one byte
   typedef struct packed {
      logic                 dig;
      logic                 oct;
      logic                 hex;
      logic                 word_start;
      logic                 word;
      logic                 blank;
      logic [KIND_BITS-1:0] single_kind;
   } char_class_type;

   // one queued input beat
   typedef struct packed {
      logic [7:0]     text_byte;
      logic           end_of_text;
      char_class_type cls;
   } item_type;

   // one token as shown on the result ports
   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [OUT_BITS-1:0]  start;
      logic [OUT_BITS-1:0]  length;
      logic [OUT_BITS-1:0]  line;
      logic [OUT_BITS-1:0]  column;
   } token_type;

   // one result beat
   typedef struct packed {
      token_type tok;
      logic      last;
   } result_type;

   // kind of a byte that forms a token by itself
   function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] b);
      logic [KIND_BITS-1:0] k;
      case (b)
         "+": k = K_PLUS;
         "*": k = K_STAR;
         "/": k = K_SLASH;
         "%": k = K_PERCENT;
         "^": k = K_CARET;
         "~": k = K_TILDE;
         "(": k = K_LPAREN;
         ")": k = K_RPAREN;
         "{": k = K_LBRACE;
         "}": k = K_RBRACE;
         "[": k = K_LBRACKET;
         "]": k = K_RBRACKET;
         ";": k = K_SEMI;
         ",": k = K_COMMA;
         ".": k = K_DOT;
         ":": k = K_COLON;
         "?": k = K_QUESTION;
         default: k = K_UNKNOWN;
      endcase
      return k;
   endfunction

   // classify one byte
   function automatic char_class_type classify(input logic [7:0] b);
      char_class_type c;
      logic           alpha;
      alpha = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
      c.dig = b >= "0" && b <= "9";
      c.oct = b >= "0" && b <= "7";
      c.hex = c.dig || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
      c.word_start = alpha || b == "_";
      c.word = c.word_start || c.dig;
      c.blank = b == " " || b == 8'h09 || b == 8'h0D || b == 8'h0A;
      c.single_kind = single_kind(b);
      return c;
   endfunction

   // keyword lookup on the first bytes of a word, byte 0 in the low bits
   function automatic logic [KIND_BITS-1:0] keyword_kind(input logic [55:0] p,
                                                         input logic [2:0] n);
      logic [KIND_BITS-1:0] k;
      k = K_IDENT;
      case (n)
         3'd2: begin
            if (p[15:0] == {"f", "i"}) k = K_KW_IF;
            else if (p[15:0] == {"n", "f"}) k = K_KW_FN;
            else if (p[15:0] == {"r", "o"}) k = K_OR;
         end
         3'd3: begin
            if (p[23:0] == {"t", "n", "i"}) k = K_KW_INT;
            else if (p[23:0] == {"r", "a", "v"}) k = K_KW_VAR;
            else if (p[23:0] == {"d", "n", "a"}) k = K_AND;
            else if (p[23:0] == {"t", "o", "n"}) k = K_NOT;
         end
         3'd4: begin
            if (p[31:0] == {"e", "u", "r", "t"}) k = K_KW_TRUE;
            else if (p[31:0] == {"l", "l", "u", "n"}) k = K_KW_NULL;
            else if (p[31:0] == {"e", "s", "l", "e"}) k = K_KW_ELSE;
         end
         3'd5: begin
            if (p[39:0] == {"e", "s", "l", "a", "f"}) k = K_KW_FALSE;
            else if (p[39:0] == {"e", "l", "i", "h", "w"}) k = K_KW_WHILE;
         end
         3'd6: begin
            if (p[47:0] == {"g", "n", "i", "r", "t", "s"}) k = K_KW_STRING;
            else if (p[47:0] == {"n", "r", "u", "t", "e", "r"}) k = K_KW_RETURN;
         end
         3'd7: begin
            if (p[55:0] == {"n", "a", "e", "l", "o", "o", "b"}) k = K_KW_BOOLEAN;
         end
         default: k = K_IDENT;
      endcase
      return k;
   endfunction

endpackage

@@ hw/rtl/stt_fifo.sv @@
// small first-word-fall-through queue built from registers
module stt_fifo #(
   parameter int WIDTH      = 8,
   parameter int DEPTH_BITS = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int DEPTH = 1 << DEPTH_BITS;

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [DEPTH_BITS:0] wr_ptr_ff, wr_ptr_in;
   logic [DEPTH_BITS:0] rd_ptr_ff, rd_ptr_in;
   logic                do_wr, do_rd;

   // pointer compare, extra bit tells full from empty
   assign empty = wr_ptr_ff == rd_ptr_ff;
   assign full  = (wr_ptr_ff[DEPTH_BITS] != rd_ptr_ff[DEPTH_BITS]) &&
                  (wr_ptr_ff[DEPTH_BITS-1:0] == rd_ptr_ff[DEPTH_BITS-1:0]);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff[DEPTH_BITS-1:0]];

   // next pointers
   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   end

   // pointer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff[DEPTH_BITS-1:0]] <= wr_data;
      end
   end

endmodule

@@ hw/rtl/stt_front.sv @@
// front end: takes input beats, classifies each byte and queues it for the lexer
module stt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [7:0]        text_byte,
   input  logic              end_of_text,
   output stt_pkg::item_type head,
   output logic              head_valid,
   input  logic              head_pop
);

   localparam int ITEM_BITS = $bits(stt_pkg::item_type);

   stt_pkg::item_type    item;
   logic [ITEM_BITS-1:0] q_data;
   logic                 q_empty;

   // classify the incoming byte
   always_comb begin
      item.text_byte   = text_byte;
      item.end_of_text = end_of_text;
      item.cls         = stt_pkg::classify(text_byte);
   end

   // byte queue between front and lexer
   stt_fifo #(
      .WIDTH      (ITEM_BITS),
      .DEPTH_BITS (stt_pkg::QUEUE_DEPTH_BITS)
   ) u_byte_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (item),
      .full    (full),
      .rd_en   (head_pop),
      .rd_data (q_data),
      .empty   (q_empty)
   );

   assign head       = stt_pkg::item_type'(q_data);
   assign head_valid = !q_empty;

endmodule

@@ hw/rtl/stt_back.sv @@
// lexer back end: one dispatch step per cycle when the result queue has room, backtrack replay, end-of-text flush
`include "assert_macros.svh"

module stt_back #(
   parameter int POS_BITS      = 24,
   parameter int KEYWORD_BYTES = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  stt_pkg::item_type   head,
   input  logic                head_valid,
   output logic                head_pop,
   output logic                res_push,
   output stt_pkg::result_type res_data,
   input  logic                res_full
);

   localparam int P        = POS_BITS;
   localparam int PFX_BITS = 8 * KEYWORD_BYTES;
   localparam int OB       = stt_pkg::OUT_BITS;
   localparam logic [P-1:0] POS_ZERO = '0;
   localparam logic [P-1:0] POS_ONE  = {{(P-1){1'b0}}, 1'b1};
   localparam logic [P-1:0] POS_TWO  = {{(P-2){1'b0}}, 2'b10};
   localparam logic [P-1:0] POS_MAX  = '1;

   // lexer modes
   localparam logic [4:0] M_IDLE = 5'd0, M_COMMENT = 5'd1, M_STRING = 5'd2;
   localparam logic [4:0] M_IDENT = 5'd3, M_OP_MINUS = 5'd4, M_OP_EQ = 5'd5;
   localparam logic [4:0] M_OP_BANG = 5'd6, M_OP_LT = 5'd7, M_OP_GT = 5'd8;
   localparam logic [4:0] M_OP_AMP = 5'd9, M_OP_BAR = 5'd10, M_ZERO = 5'd11;
   localparam logic [4:0] M_ZERO_X = 5'd12, M_HEX = 5'd13, M_OCT = 5'd14;
   localparam logic [4:0] M_DEC = 5'd15, M_FRAC_D = 5'd16, M_FRAC_H = 5'd17;
   localparam logic [4:0] M_EXP_MARK = 5'd18, M_EXP_SIGN = 5'd19, M_EXP_DIG = 5'd20;
   localparam logic [4:0] M_HEXP_MARK = 5'd21, M_HEXP_SIGN = 5'd22;
   localparam logic [4:0] M_HEXP_DIG = 5'd23;

   // outcome of one dispatch step
   localparam logic [1:0] ACT_DONE = 2'd0, ACT_AGAIN = 2'd1, ACT_BACK = 2'd2;

   // lexer state
   logic [4:0]          mode_ff, mode_in;
   logic                quote_ff, quote_in;
   logic [23:0]         pend_ff, pend_in;
   logic [1:0]          pcnt_ff, pcnt_in;
   logic [PFX_BITS-1:0] prefix_ff, prefix_in;
   logic [P-1:0]        ts_ff, ts_in;
   logic [P-1:0]        tcol_ff, tcol_in;
   logic [P-1:0]        tlen_ff, tlen_in;
   logic [P-1:0]        off_ff, off_in;
   logic [P-1:0]        line_ff, line_in;
   logic [P-1:0]        col_ff, col_in;
   // replay bytes after a number backs off
   logic [23:0]         rq_ff, rq_in;
   logic [1:0]          rc_ff, rc_in;
   logic                flush_ff, flush_in;
   // token held until it is known whether it closes its run
   stt_pkg::token_type  held_ff, held_in;
   logic                held_v_ff, held_v_in;
   logic                held_closed_ff, held_closed_in;

   logic                         src_replay, step, flush_tail;
   logic [7:0]                   b;
   stt_pkg::char_class_type      cls;
   logic [1:0]                   act;
   logic                         nv, inc_len, push_b, commit_p, end_num, run_done, fin;
   logic [stt_pkg::KIND_BITS-1:0] ev_kind, end_kind, word_kind, pair_kind;
   logic                         pair_hit, tlen_small;
   logic [P-1:0]                 ev_start, ev_len;
   logic                         tok_fire, run_end;
   stt_pkg::token_type           new_tok;

   function automatic logic [P-1:0] sat_add(input logic [P-1:0] a, input logic [P-1:0] c);
      logic [P:0] s;
      s = {1'b0, a} + {1'b0, c};
      return s[P] ? POS_MAX : s[P-1:0];
   endfunction

   function automatic logic [OB-1:0] to_out(input logic [P-1:0] v);
      logic [P+OB-1:0] w;
      w = {{OB{1'b0}}, v};
      return w[OB-1:0];
   endfunction

   function automatic logic [stt_pkg::KIND_BITS-1:0] op_single(input logic [4:0] m);
      logic [stt_pkg::KIND_BITS-1:0] k;
      case (m)
         M_OP_MINUS: k = stt_pkg::K_MINUS;
         M_OP_EQ:    k = stt_pkg::K_ASSIGN;
         M_OP_BANG:  k = stt_pkg::K_NOT;
         M_OP_LT:    k = stt_pkg::K_LESS;
         M_OP_GT:    k = stt_pkg::K_GREATER;
         M_OP_AMP:   k = stt_pkg::K_AMP;
         default:    k = stt_pkg::K_BAR;
      endcase
      return k;
   endfunction

   // byte source: replay bytes first, then the queue head
   assign src_replay = rc_ff != 2'd0;
   assign b          = src_replay ? rq_ff[7:0] : head.text_byte;
   assign cls        = src_replay ? stt_pkg::classify(rq_ff[7:0]) : head.cls;
   assign flush_tail = flush_ff && !src_replay;
   assign step       = !res_full && (src_replay || flush_ff || head_valid);

   // keyword match on the word collected so far
   assign tlen_small = (tlen_ff >> 3) == POS_ZERO;
   assign word_kind  = tlen_small ? stt_pkg::keyword_kind(prefix_ff[55:0], tlen_ff[2:0])
                                  : stt_pkg::K_IDENT;

   // second character of a two-character operator
   always_comb begin
      pair_hit  = 1'b0;
      pair_kind = stt_pkg::K_UNKNOWN;
      case (mode_ff)
         M_OP_MINUS: if (b == ">") begin pair_hit = 1'b1; pair_kind = stt_pkg::K_ARROW; end
         M_OP_EQ:    if (b == "=") begin pair_hit = 1'b1; pair_kind = stt_pkg::K_EQ_EQ; end
         M_OP_BANG:  if (b == "=") begin pair_hit = 1'b1; pair_kind = stt_pkg::K_NOT_EQ; end
         M_OP_LT: begin
            if (b == "=") begin pair_hit = 1'b1; pair_kind = stt_pkg::K_LESS_EQ; end
            else if (b == "<") begin pair_hit = 1'b1; pair_kind = stt_pkg::K_SHL; end
         end
         M_OP_GT: begin
            if (b == "=") begin pair_hit = 1'b1; pair_kind = stt_pkg::K_GREATER_EQ; end
            else if (b == ">") begin pair_hit = 1'b1; pair_kind = stt_pkg::K_SHR; end
         end
         M_OP_AMP:   if (b == "&") begin pair_hit = 1'b1; pair_kind = stt_pkg::K_AND; end
         M_OP_BAR:   if (b == "|") begin pair_hit = 1'b1; pair_kind = stt_pkg::K_OR; end
         default: begin
            pair_hit  = 1'b0;
            pair_kind = stt_pkg::K_UNKNOWN;
         end
      endcase
   end

   // one dispatch step
   always_comb begin
      mode_in   = mode_ff;
      quote_in  = quote_ff;
      pend_in   = pend_ff;
      pcnt_in   = pcnt_ff;
      prefix_in = prefix_ff;
      ts_in     = ts_ff;
      tcol_in   = tcol_ff;
      tlen_in   = tlen_ff;
      off_in    = off_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      rq_in     = rq_ff;
      rc_in     = rc_ff;
      flush_in  = flush_ff;
      head_pop  = 1'b0;
      act       = ACT_DONE;
      nv        = 1'b0;
      ev_kind   = stt_pkg::K_IDENT;
      ev_start  = ts_ff;
      ev_len    = tlen_ff;
      inc_len   = 1'b0;
      push_b    = 1'b0;
      commit_p  = 1'b0;
      end_num   = 1'b0;
      end_kind  = stt_pkg::K_INT_LIT;
      run_done  = 1'b0;
      fin       = 1'b0;

      if (flush_tail) begin
         // close whatever token is open at end of text
         case (mode_ff)
            M_IDLE: fin = 1'b1;
            M_IDENT: begin
               nv      = 1'b1;
               ev_kind = word_kind;
               mode_in = M_IDLE;
            end
            M_STRING: begin
               nv      = 1'b1;
               ev_kind = stt_pkg::K_UNTERM;
               mode_in = M_IDLE;
            end
            M_OP_MINUS, M_OP_EQ, M_OP_BANG, M_OP_LT, M_OP_GT, M_OP_AMP, M_OP_BAR: begin
               nv      = 1'b1;
               ev_kind = op_single(mode_ff);
               ev_len  = POS_ONE;
               mode_in = M_IDLE;
            end
            M_ZERO, M_ZERO_X, M_HEX, M_OCT, M_DEC: begin
               end_num  = 1'b1;
               end_kind = stt_pkg::K_INT_LIT;
            end
            M_FRAC_D, M_FRAC_H, M_EXP_MARK, M_EXP_SIGN, M_EXP_DIG,
            M_HEXP_MARK, M_HEXP_SIGN, M_HEXP_DIG: begin
               end_num  = 1'b1;
               end_kind = stt_pkg::K_FLOAT_LIT;
            end
            default: mode_in = M_IDLE;
         endcase
      end else begin
         case (mode_ff)
            M_IDLE: begin
               if (cls.blank) begin
                  act = ACT_DONE;
               end else if (b == "#") begin
                  mode_in = M_COMMENT;
               end else begin
                  ts_in   = off_ff;
                  tcol_in = col_ff;
                  tlen_in = POS_ONE;
                  if (cls.dig) begin
                     mode_in = (b == "0") ? M_ZERO : M_DEC;
                  end else if (b == 8'h22 || b == 8'h27) begin
                     mode_in  = M_STRING;
                     quote_in = b == 8'h27;
                     ts_in    = sat_add(off_ff, POS_ONE);
                     tlen_in  = POS_ZERO;
                  end else if (cls.word_start) begin
                     mode_in   = M_IDENT;
                     prefix_in = {{(PFX_BITS-8){1'b0}}, b};
                  end else if (b == "-") begin
                     mode_in = M_OP_MINUS;
                  end else if (b == "=") begin
                     mode_in = M_OP_EQ;
                  end else if (b == "!") begin
                     mode_in = M_OP_BANG;
                  end else if (b == "<") begin
                     mode_in = M_OP_LT;
                  end else if (b == ">") begin
                     mode_in = M_OP_GT;
                  end else if (b == "&") begin
                     mode_in = M_OP_AMP;
                  end else if (b == "|") begin
                     mode_in = M_OP_BAR;
                  end else begin
                     nv       = 1'b1;
                     ev_kind  = cls.single_kind;
                     ev_start = off_ff;
                     ev_len   = POS_ONE;
                  end
               end
            end
            M_COMMENT: begin
               if (b == 8'h0A) mode_in = M_IDLE;
            end
            M_STRING: begin
               if (b == (quote_ff ? 8'h27 : 8'h22)) begin
                  nv      = 1'b1;
                  ev_kind = stt_pkg::K_STRING_LIT;
                  mode_in = M_IDLE;
               end else begin
                  inc_len = 1'b1;
               end
            end
            M_IDENT: begin
               if (!cls.word) begin
                  nv      = 1'b1;
                  ev_kind = word_kind;
                  mode_in = M_IDLE;
                  act     = ACT_AGAIN;
               end else begin
                  for (int i = 0; i < KEYWORD_BYTES; i++) begin
                     if (tlen_small && tlen_ff[2:0] == 3'(i)) begin
                        prefix_in[8*i +: 8] = prefix_ff[8*i +: 8] | b;
                     end
                  end
                  inc_len = 1'b1;
               end
            end
            M_OP_MINUS, M_OP_EQ, M_OP_BANG, M_OP_LT, M_OP_GT, M_OP_AMP, M_OP_BAR: begin
               nv      = 1'b1;
               mode_in = M_IDLE;
               if (pair_hit) begin
                  ev_kind = pair_kind;
                  ev_len  = POS_TWO;
               end else begin
                  ev_kind = op_single(mode_ff);
                  ev_len  = POS_ONE;
                  act     = ACT_AGAIN;
               end
            end
            M_ZERO: begin
               if (b == "x" || b == "X") begin
                  push_b  = 1'b1;
                  mode_in = M_ZERO_X;
               end else if (cls.oct) begin
                  inc_len = 1'b1;
                  mode_in = M_OCT;
               end else if (b == ".") begin
                  inc_len = 1'b1;
                  mode_in = M_FRAC_D;
               end else begin
                  end_num = 1'b1;
               end
            end
            M_ZERO_X: begin
               if (cls.hex) begin
                  commit_p = 1'b1;
                  mode_in  = M_HEX;
               end else begin
                  end_num = 1'b1;
               end
            end
            M_HEX, M_OCT, M_DEC: begin
               if ((mode_ff == M_HEX && cls.hex) || (mode_ff == M_OCT && cls.oct) ||
                   (mode_ff == M_DEC && cls.dig)) begin
                  inc_len = 1'b1;
               end else if (b == ".") begin
                  inc_len = 1'b1;
                  mode_in = (mode_ff == M_HEX) ? M_FRAC_H : M_FRAC_D;
               end else begin
                  end_num = 1'b1;
               end
            end
            M_FRAC_D, M_FRAC_H: begin
               if ((mode_ff == M_FRAC_D) ? cls.dig : cls.hex) begin
                  inc_len = 1'b1;
               end else if (mode_ff == M_FRAC_D && (b == "e" || b == "E")) begin
                  push_b  = 1'b1;
                  mode_in = M_EXP_MARK;
               end else if (mode_ff == M_FRAC_H && (b == "p" || b == "P")) begin
                  push_b  = 1'b1;
                  mode_in = M_HEXP_MARK;
               end else begin
                  end_num  = 1'b1;
                  end_kind = stt_pkg::K_FLOAT_LIT;
               end
            end
            M_EXP_MARK, M_HEXP_MARK: begin
               if (cls.dig) begin
                  commit_p = 1'b1;
                  mode_in  = (mode_ff == M_EXP_MARK) ? M_EXP_DIG : M_HEXP_DIG;
               end else if (b == "+" || b == "-") begin
                  push_b  = 1'b1;
                  mode_in = (mode_ff == M_EXP_MARK) ? M_EXP_SIGN : M_HEXP_SIGN;
               end else begin
                  end_num  = 1'b1;
                  end_kind = stt_pkg::K_FLOAT_LIT;
               end
            end
            M_EXP_SIGN, M_HEXP_SIGN: begin
               if (cls.dig) begin
                  commit_p = 1'b1;
                  mode_in  = (mode_ff == M_EXP_SIGN) ? M_EXP_DIG : M_HEXP_DIG;
               end else begin
                  end_num  = 1'b1;
                  end_kind = stt_pkg::K_FLOAT_LIT;
               end
            end
            M_EXP_DIG, M_HEXP_DIG: begin
               if (cls.dig) begin
                  inc_len = 1'b1;
               end else begin
                  end_num  = 1'b1;
                  end_kind = stt_pkg::K_FLOAT_LIT;
               end
            end
            default: begin
               mode_in = M_IDLE;
               act     = ACT_AGAIN;
            end
         endcase
      end

      // length and backtrack bookkeeping
      if (inc_len) tlen_in = sat_add(tlen_ff, POS_ONE);
      if (push_b && pcnt_ff != 2'd3) begin
         pend_in[{pcnt_ff, 3'b000} +: 8] = b;
         pcnt_in = pcnt_ff + 2'd1;
      end
      if (commit_p) begin
         tlen_in = sat_add(tlen_ff, {{(P-2){1'b0}}, pcnt_ff} + POS_ONE);
         pend_in = '0;
         pcnt_in = 2'd0;
      end

      // number ends: emit it and hand any held-back bytes to the replay buffer
      if (end_num) begin
         nv      = 1'b1;
         ev_kind = end_kind;
         mode_in = M_IDLE;
         if (pcnt_ff == 2'd0) begin
            act = ACT_AGAIN;
         end else begin
            act     = ACT_BACK;
            off_in  = sat_add(ts_ff, tlen_ff);
            col_in  = sat_add(tcol_ff, tlen_ff);
            rq_in   = pend_ff;
            rc_in   = pcnt_ff;
            pend_in = '0;
            pcnt_in = 2'd0;
         end
      end

      // byte used up: move position and retire it
      if (!flush_tail && act == ACT_DONE) begin
         off_in = sat_add(off_ff, POS_ONE);
         if (b == 8'h0A) begin
            line_in = sat_add(line_ff, POS_ONE);
            col_in  = POS_ONE;
         end else begin
            col_in = sat_add(col_ff, POS_ONE);
         end
         if (src_replay) begin
            rq_in = {8'h00, rq_ff[23:8]};
            rc_in = rc_ff - 2'd1;
         end else begin
            head_pop = step;
            if (head.end_of_text) flush_in = 1'b1;
            else run_done = 1'b1;
         end
      end

      // end of text fully flushed: back to reset state
      if (fin) begin
         mode_in   = M_IDLE;
         quote_in  = 1'b0;
         pend_in   = '0;
         pcnt_in   = 2'd0;
         prefix_in = '0;
         ts_in     = POS_ZERO;
         tcol_in   = POS_ONE;
         tlen_in   = POS_ZERO;
         off_in    = POS_ZERO;
         line_in   = POS_ONE;
         col_in    = POS_ONE;
         flush_in  = 1'b0;
         run_done  = 1'b1;
      end
   end

   // held token and result push
   always_comb begin
      new_tok.kind   = ev_kind;
      new_tok.start  = to_out(ev_start);
      new_tok.length = to_out(ev_len);
      new_tok.line   = to_out(line_ff);
      new_tok.column = to_out(tcol_in);
      tok_fire = step && nv;
      run_end  = step && run_done;
      res_push = held_v_ff && !res_full && (held_closed_ff || tok_fire || run_end);
      res_data.tok  = held_ff;
      res_data.last = held_closed_ff || !tok_fire;
      held_in        = held_ff;
      held_v_in      = held_v_ff;
      held_closed_in = held_closed_ff;
      if (tok_fire) begin
         held_in        = new_tok;
         held_v_in      = 1'b1;
         held_closed_in = run_end;
      end else if (res_push) begin
         held_v_in      = 1'b0;
         held_closed_in = 1'b0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= M_IDLE;
         quote_ff       <= 1'b0;
         pend_ff        <= '0;
         pcnt_ff        <= 2'd0;
         prefix_ff      <= '0;
         ts_ff          <= POS_ZERO;
         tcol_ff        <= POS_ONE;
         tlen_ff        <= POS_ZERO;
         off_ff         <= POS_ZERO;
         line_ff        <= POS_ONE;
         col_ff         <= POS_ONE;
         rc_ff          <= 2'd0;
         flush_ff       <= 1'b0;
         held_v_ff      <= 1'b0;
         held_closed_ff <= 1'b0;
      end else begin
         if (step) begin
            mode_ff   <= mode_in;
            quote_ff  <= quote_in;
            pend_ff   <= pend_in;
            pcnt_ff   <= pcnt_in;
            prefix_ff <= prefix_in;
            ts_ff     <= ts_in;
            tcol_ff   <= tcol_in;
            tlen_ff   <= tlen_in;
            off_ff    <= off_in;
            line_ff   <= line_in;
            col_ff    <= col_in;
            rc_ff     <= rc_in;
            flush_ff  <= flush_in;
         end
         held_v_ff      <= held_v_in;
         held_closed_ff <= held_closed_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (step) rq_ff <= rq_in;
      held_ff <= held_in;
   end

   `STT_ASSERT(a_backtrack_from_head, clock, reset, (step && act == ACT_BACK) |-> !src_replay, "backtrack while replaying")
   `STT_ASSERT_NEVER(a_pending_overflow, clock, reset, pcnt_ff == 2'd3, "more than two held-back bytes")
   `STT_ASSERT(a_push_has_room, clock, reset, res_push |-> !res_full, "token pushed into full queue")
   `STT_ASSERT(a_flush_keeps_head, clock, reset, flush_ff |-> !head_pop, "byte taken during end-of-text flush")

endmodule

@@ hw/rtl/source_text_tokenizer_core.sv @@
// Source text tokenizer: bytes in through a queue, tokens out through a queue.
// The lexer step unit in the back end handles one byte dispatch per cycle while
// the token queue is not full and a byte or flush step is pending; a byte that
// closes an identifier, number or operator and must then be looked at again is
// dispatched a second time, each byte held back for number backtracking (at most
// two) is replayed afterwards, and a byte flagged end_of_text then starts a flush
// that closes each token or comment still open and replays each held-back byte
// before returning to the reset state. A token waits in a one-entry hold register
// until it is known whether it is the last of its byte, so it passes through the
// hold register and then the token queue before it reaches the result ports.
// Results are not dropped under stall; push accepts while full is low.
module source_text_tokenizer_core #(
   parameter int POS_BITS      = 24,
   parameter int KEYWORD_BYTES = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        empty,
   input  logic        pop,
   output logic [5:0]  rsp_token_kind,
   output logic [23:0] rsp_start_offset,
   output logic [23:0] rsp_token_length,
   output logic [23:0] rsp_line_number,
   output logic [23:0] rsp_column_number,
   output logic        rsp_last_of_run
);

   localparam int RES_BITS = $bits(stt_pkg::result_type);

   stt_pkg::item_type   head;
   logic                head_valid, head_pop;
   logic                res_push, res_full;
   stt_pkg::result_type res_data, res_out;
   logic [RES_BITS-1:0] res_q;

   // byte intake and classification
   stt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .head        (head),
      .head_valid  (head_valid),
      .head_pop    (head_pop)
   );

   // lexer
   stt_back #(
      .POS_BITS      (POS_BITS),
      .KEYWORD_BYTES (KEYWORD_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .res_push   (res_push),
      .res_data   (res_data),
      .res_full   (res_full)
   );

   // token queue toward the consumer
   stt_fifo #(
      .WIDTH      (RES_BITS),
      .DEPTH_BITS (stt_pkg::QUEUE_DEPTH_BITS)
   ) u_token_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_push),
      .wr_data (res_data),
      .full    (res_full),
      .rd_en   (pop),
      .rd_data (res_q),
      .empty   (empty)
   );

   assign res_out           = stt_pkg::result_type'(res_q);
   assign rsp_token_kind    = res_out.tok.kind;
   assign rsp_start_offset  = res_out.tok.start;
   assign rsp_token_length  = res_out.tok.length;
   assign rsp_line_number   = res_out.tok.line;
   assign rsp_column_number = res_out.tok.column;
   assign rsp_last_of_run   = res_out.last;

endmodule

@@ dv/tb_source_text_tokenizer_core.sv @@
// testbench for the source text tokenizer: directed and random byte streams checked per token
`timescale 1ns / 1ps

module tb_source_text_tokenizer_core;

   localparam longint unsigned POS_LIMIT = (64'd1 << 24) - 1;

   // lexer states of the token predictor, ordered so that ranges can be tested
   typedef enum int {
      LX_IDLE, LX_COMMENT, LX_STR, LX_WORD, LX_MINUS, LX_EQ, LX_BANG, LX_LT, LX_GT,
      LX_AMP, LX_BAR, LX_ZERO, LX_ZERO_X, LX_HEX, LX_OCT, LX_DEC, LX_FRAC_D, LX_FRAC_H,
      LX_EXP_MARK, LX_EXP_SIGN, LX_EXP_DIG, LX_HEXP_MARK, LX_HEXP_SIGN, LX_HEXP_DIG
   } lex_state_type;

   // outcome of looking at one byte
   typedef enum int {LOOK_DONE, LOOK_AGAIN, LOOK_BACK} look_type;

   typedef struct {
      logic [5:0]  kind;
      logic [23:0] start;
      logic [23:0] length;
      logic [23:0] line;
      logic [23:0] column;
      logic        last;
   } exp_token_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_text_byte = '0;
   logic        req_end_of_text = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [5:0]  rsp_token_kind;
   logic [23:0] rsp_start_offset;
   logic [23:0] rsp_token_length;
   logic [23:0] rsp_line_number;
   logic [23:0] rsp_column_number;
   logic        rsp_last_of_run;

   source_text_tokenizer_core dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_text_byte(req_text_byte), .req_end_of_text(req_end_of_text),
      .empty(empty), .pop(pop),
      .rsp_token_kind(rsp_token_kind), .rsp_start_offset(rsp_start_offset),
      .rsp_token_length(rsp_token_length), .rsp_line_number(rsp_line_number),
      .rsp_column_number(rsp_column_number), .rsp_last_of_run(rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   lex_state_type   lex_state;
   bit              single_quote;
   logic [7:0]      held_bytes[$];
   logic [55:0]     word_bytes;
   longint unsigned tok_start, tok_column, tok_len;
   longint unsigned text_offset, text_line, text_column;

   exp_token_type step_tokens[$];
   exp_token_type expected_tokens[$];
   int     mismatches = 0;
   int     tokens_checked = 0;
   int     bytes_sent = 0;
   int     runs_sent = 0;

   string       kw_text[15] = '{"int", "boolean", "string", "true", "false", "null", "if",
                                "else", "while", "var", "fn", "return", "and", "or", "not"};
   logic [5:0]  kw_kind[15] = '{stt_pkg::K_KW_INT, stt_pkg::K_KW_BOOLEAN,
                                stt_pkg::K_KW_STRING, stt_pkg::K_KW_TRUE,
                                stt_pkg::K_KW_FALSE, stt_pkg::K_KW_NULL, stt_pkg::K_KW_IF,
                                stt_pkg::K_KW_ELSE, stt_pkg::K_KW_WHILE, stt_pkg::K_KW_VAR,
                                stt_pkg::K_KW_FN, stt_pkg::K_KW_RETURN, stt_pkg::K_AND,
                                stt_pkg::K_OR, stt_pkg::K_NOT};

   function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s > POS_LIMIT) ? POS_LIMIT : s;
   endfunction

   function automatic bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic bit is_hexdig(logic [7:0] b);
      return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
   endfunction

   function automatic bit is_letter(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic void clear_lexer();
      lex_state = LX_IDLE;
      single_quote = 0;
      held_bytes.delete();
      word_bytes = '0;
      tok_start = 0;
      tok_column = 1;
      tok_len = 0;
      text_offset = 0;
      text_line = 1;
      text_column = 1;
   endfunction

   function automatic void add_token(logic [5:0] kind, longint unsigned start,
                                     longint unsigned len);
      exp_token_type t;
      if (step_tokens.size() >= 5) return;
      t.kind = kind;
      t.start = start[23:0];
      t.length = len[23:0];
      t.line = text_line[23:0];
      t.column = tok_column[23:0];
      t.last = 1'b0;
      step_tokens.push_back(t);
   endfunction

   function automatic void add_word();
      logic [5:0] kind;
      bit         same;
      kind = stt_pkg::K_IDENT;
      for (int k = 0; k < 15; k++) begin
         same = tok_len == kw_text[k].len();
         for (int i = 0; same && i < kw_text[k].len(); i++)
            if (word_bytes[8*i +: 8] != kw_text[k][i]) same = 0;
         if (same) kind = kw_kind[k];
      end
      add_token(kind, tok_start, tok_len);
   endfunction

   function automatic logic [5:0] lone_operator(lex_state_type s);
      case (s)
         LX_MINUS: return stt_pkg::K_MINUS;
         LX_EQ:    return stt_pkg::K_ASSIGN;
         LX_BANG:  return stt_pkg::K_NOT;
         LX_LT:    return stt_pkg::K_LESS;
         LX_GT:    return stt_pkg::K_GREATER;
         LX_AMP:   return stt_pkg::K_AMP;
         default:  return stt_pkg::K_BAR;
      endcase
   endfunction

   function automatic void hold_byte(logic [7:0] b);
      if (held_bytes.size() < 3) held_bytes.push_back(b);
   endfunction

   function automatic void take_held();
      tok_len = sat_sum(tok_len, held_bytes.size() + 1);
      held_bytes.delete();
   endfunction

   // close a number; held bytes are looked at again from the end of the token
   function automatic look_type close_number(logic [5:0] kind);
      add_token(kind, tok_start, tok_len);
      lex_state = LX_IDLE;
      if (held_bytes.size() == 0) return LOOK_AGAIN;
      text_offset = sat_sum(tok_start, tok_len);
      text_column = sat_sum(tok_column, tok_len);
      return LOOK_BACK;
   endfunction

   function automatic look_type look_idle(logic [7:0] b);
      logic [5:0] kind;
      if (b == 8'h0A || b == " " || b == 8'h09 || b == 8'h0D) return LOOK_DONE;
      if (b == "#") begin
         lex_state = LX_COMMENT;
         return LOOK_DONE;
      end
      tok_start = text_offset;
      tok_column = text_column;
      tok_len = 1;
      if (is_digit(b)) begin
         lex_state = (b == "0") ? LX_ZERO : LX_DEC;
         return LOOK_DONE;
      end
      if (b == "\"" || b == "'") begin
         lex_state = LX_STR;
         single_quote = b == "'";
         tok_start = sat_sum(text_offset, 1);
         tok_len = 0;
         return LOOK_DONE;
      end
      if (is_letter(b) || b == "_") begin
         lex_state = LX_WORD;
         word_bytes = {48'd0, b};
         return LOOK_DONE;
      end
      case (b)
         "-": lex_state = LX_MINUS;
         "=": lex_state = LX_EQ;
         "!": lex_state = LX_BANG;
         "<": lex_state = LX_LT;
         ">": lex_state = LX_GT;
         "&": lex_state = LX_AMP;
         "|": lex_state = LX_BAR;
         default: begin
            case (b)
               "+": kind = stt_pkg::K_PLUS;
               "*": kind = stt_pkg::K_STAR;
               "/": kind = stt_pkg::K_SLASH;
               "%": kind = stt_pkg::K_PERCENT;
               "^": kind = stt_pkg::K_CARET;
               "~": kind = stt_pkg::K_TILDE;
               "(": kind = stt_pkg::K_LPAREN;
               ")": kind = stt_pkg::K_RPAREN;
               "{": kind = stt_pkg::K_LBRACE;
               "}": kind = stt_pkg::K_RBRACE;
               "[": kind = stt_pkg::K_LBRACKET;
               "]": kind = stt_pkg::K_RBRACKET;
               ";": kind = stt_pkg::K_SEMI;
               ",": kind = stt_pkg::K_COMMA;
               ".": kind = stt_pkg::K_DOT;
               ":": kind = stt_pkg::K_COLON;
               "?": kind = stt_pkg::K_QUESTION;
               default: kind = stt_pkg::K_UNKNOWN;
            endcase
            add_token(kind, tok_start, 1);
         end
      endcase
      return LOOK_DONE;
   endfunction

   function automatic look_type look_operator(logic [7:0] b);
      logic [5:0] kind;
      bit         pair;
      pair = 1;
      case (lex_state)
         LX_MINUS: if (b == ">") kind = stt_pkg::K_ARROW; else pair = 0;
         LX_EQ:    if (b == "=") kind = stt_pkg::K_EQ_EQ; else pair = 0;
         LX_BANG:  if (b == "=") kind = stt_pkg::K_NOT_EQ; else pair = 0;
         LX_LT: begin
            if (b == "=") kind = stt_pkg::K_LESS_EQ;
            else if (b == "<") kind = stt_pkg::K_SHL;
            else pair = 0;
         end
         LX_GT: begin
            if (b == "=") kind = stt_pkg::K_GREATER_EQ;
            else if (b == ">") kind = stt_pkg::K_SHR;
            else pair = 0;
         end
         LX_AMP:   if (b == "&") kind = stt_pkg::K_AND; else pair = 0;
         default:  if (b == "|") kind = stt_pkg::K_OR; else pair = 0;
      endcase
      if (pair) begin
         add_token(kind, tok_start, 2);
         lex_state = LX_IDLE;
         return LOOK_DONE;
      end
      add_token(lone_operator(lex_state), tok_start, 1);
      lex_state = LX_IDLE;
      return LOOK_AGAIN;
   endfunction

   function automatic look_type look_byte(logic [7:0] b);
      case (lex_state)
         LX_IDLE: return look_idle(b);
         LX_COMMENT: begin
            if (b == 8'h0A) lex_state = LX_IDLE;
            return LOOK_DONE;
         end
         LX_STR: begin
            if (b == (single_quote ? "'" : "\"")) begin
               add_token(stt_pkg::K_STRING_LIT, tok_start, tok_len);
               lex_state = LX_IDLE;
            end else tok_len = sat_sum(tok_len, 1);
            return LOOK_DONE;
         end
         LX_WORD: begin
            if (!(is_letter(b) || is_digit(b) || b == "_")) begin
               add_word();
               lex_state = LX_IDLE;
               return LOOK_AGAIN;
            end
            if (tok_len < 7) word_bytes[8*tok_len +: 8] = b;
            tok_len = sat_sum(tok_len, 1);
            return LOOK_DONE;
         end
         LX_ZERO: begin
            if (b == "x" || b == "X") begin
               hold_byte(b);
               lex_state = LX_ZERO_X;
               return LOOK_DONE;
            end
            if (b >= "0" && b <= "7") begin
               tok_len = sat_sum(tok_len, 1);
               lex_state = LX_OCT;
               return LOOK_DONE;
            end
            if (b == ".") begin
               tok_len = sat_sum(tok_len, 1);
               lex_state = LX_FRAC_D;
               return LOOK_DONE;
            end
            return close_number(stt_pkg::K_INT_LIT);
         end
         LX_ZERO_X: begin
            if (is_hexdig(b)) begin
               take_held();
               lex_state = LX_HEX;
               return LOOK_DONE;
            end
            return close_number(stt_pkg::K_INT_LIT);
         end
         LX_HEX, LX_OCT, LX_DEC: begin
            if ((lex_state == LX_HEX && is_hexdig(b)) ||
                (lex_state == LX_OCT && b >= "0" && b <= "7") ||
                (lex_state == LX_DEC && is_digit(b))) begin
               tok_len = sat_sum(tok_len, 1);
               return LOOK_DONE;
            end
            if (b == ".") begin
               tok_len = sat_sum(tok_len, 1);
               lex_state = (lex_state == LX_HEX) ? LX_FRAC_H : LX_FRAC_D;
               return LOOK_DONE;
            end
            return close_number(stt_pkg::K_INT_LIT);
         end
         LX_FRAC_D, LX_FRAC_H: begin
            if ((lex_state == LX_FRAC_D) ? is_digit(b) : is_hexdig(b)) begin
               tok_len = sat_sum(tok_len, 1);
               return LOOK_DONE;
            end
            if (lex_state == LX_FRAC_D && (b == "e" || b == "E")) begin
               hold_byte(b);
               lex_state = LX_EXP_MARK;
               return LOOK_DONE;
            end
            if (lex_state == LX_FRAC_H && (b == "p" || b == "P")) begin
               hold_byte(b);
               lex_state = LX_HEXP_MARK;
               return LOOK_DONE;
            end
            return close_number(stt_pkg::K_FLOAT_LIT);
         end
         LX_EXP_MARK, LX_HEXP_MARK: begin
            if (is_digit(b)) begin
               take_held();
               lex_state = (lex_state == LX_EXP_MARK) ? LX_EXP_DIG : LX_HEXP_DIG;
               return LOOK_DONE;
            end
            if (b == "+" || b == "-") begin
               hold_byte(b);
               lex_state = (lex_state == LX_EXP_MARK) ? LX_EXP_SIGN : LX_HEXP_SIGN;
               return LOOK_DONE;
            end
            return close_number(stt_pkg::K_FLOAT_LIT);
         end
         LX_EXP_SIGN, LX_HEXP_SIGN: begin
            if (is_digit(b)) begin
               take_held();
               lex_state = (lex_state == LX_EXP_SIGN) ? LX_EXP_DIG : LX_HEXP_DIG;
               return LOOK_DONE;
            end
            return close_number(stt_pkg::K_FLOAT_LIT);
         end
         LX_EXP_DIG, LX_HEXP_DIG: begin
            if (is_digit(b)) begin
               tok_len = sat_sum(tok_len, 1);
               return LOOK_DONE;
            end
            return close_number(stt_pkg::K_FLOAT_LIT);
         end
         default: return look_operator(b);
      endcase
   endfunction

   // run one byte through the lexer, replaying held bytes after a backtrack
   function automatic void lex_feed(logic [7:0] first);
      logic [7:0] work[$];
      logic [7:0] replay[$];
      int         i;
      look_type   r;
      work.push_back(first);
      i = 0;
      while (i < work.size()) begin
         r = look_byte(work[i]);
         if (r == LOOK_DONE) begin
            text_offset = sat_sum(text_offset, 1);
            if (work[i] == 8'h0A) begin
               text_line = sat_sum(text_line, 1);
               text_column = 1;
            end else text_column = sat_sum(text_column, 1);
            i++;
         end else if (r == LOOK_BACK) begin
            replay = held_bytes;
            held_bytes.delete();
            for (int k = i; k < work.size(); k++) replay.push_back(work[k]);
            work = replay;
            i = 0;
         end
      end
   endfunction

   // end of text: close whatever token is still open
   function automatic void lex_flush();
      logic [7:0] replay[$];
      for (int guard = 0; guard < 16 && lex_state != LX_IDLE; guard++) begin
         if (lex_state >= LX_ZERO) begin
            void'(close_number(lex_state >= LX_FRAC_D ? stt_pkg::K_FLOAT_LIT
                                                      : stt_pkg::K_INT_LIT));
            replay = held_bytes;
            held_bytes.delete();
            foreach (replay[k]) lex_feed(replay[k]);
            continue;
         end
         if (lex_state == LX_WORD) add_word();
         else if (lex_state == LX_STR) add_token(stt_pkg::K_UNTERM, tok_start, tok_len);
         else if (lex_state >= LX_MINUS) add_token(lone_operator(lex_state), tok_start, 1);
         lex_state = LX_IDLE;
      end
   endfunction

   function automatic void predict_tokens(logic [7:0] b, logic eot);
      step_tokens.delete();
      lex_feed(b);
      if (eot) begin
         lex_flush();
         clear_lexer();
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
      foreach (step_tokens[k]) expected_tokens.push_back(step_tokens[k]);
   endfunction

   // sender burst control
   int burst_left = 0;

   task automatic send_byte(logic [7:0] b, logic eot);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      push <= 1'b1;
      req_text_byte <= b;
      req_end_of_text <= eot;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_tokens(b, eot);
      bytes_sent++;
      if (eot) runs_sent++;
   endtask

   task automatic send_text(string s, bit eot_last);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], eot_last && i == s.len() - 1);
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // receiver: stall patterns, plus a long hold-off on request
   bit stall_request = 0;
   int hold_left = 0;
   int pattern_left = 0;
   int pattern_mode = 0;

   always @(posedge clock) begin
      if (stall_request) begin
         stall_request = 0;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern_mode = $urandom_range(0, 2);
            pattern_left = $urandom_range(10, 60);
         end else pattern_left--;
         case (pattern_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            default: pop <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // compare each popped beat with the oldest predicted token
   always @(posedge clock) begin
      exp_token_type want;
      if (!reset && pop && !empty) begin
         if (expected_tokens.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected token beat: kind %0d start %0d", rsp_token_kind,
                        rsp_start_offset);
         end else begin
            want = expected_tokens.pop_front();
            tokens_checked++;
            if (rsp_token_kind !== want.kind || rsp_start_offset !== want.start ||
                rsp_token_length !== want.length || rsp_line_number !== want.line ||
                rsp_column_number !== want.column || rsp_last_of_run !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("token mismatch: exp k%0d s%0d n%0d l%0d c%0d last%0d",
                           want.kind, want.start, want.length, want.line, want.column,
                           want.last, " / got k%0d s%0d n%0d l%0d c%0d last%0d",
                           rsp_token_kind, rsp_start_offset, rsp_token_length,
                           rsp_line_number, rsp_column_number, rsp_last_of_run);
            end
         end
      end
   end

   // keywords, identifiers and every operator
   task automatic test_words_and_operators();
      send_text("if else var fn int boolean string true false null while return", 0);
      send_text(" and or not _x9 booleans Z\n", 0);
      send_text("-> - == = != ! <= << < >= >> > && & || | + * / % ^ ~ ( ) { } [ ] ; , . : ? -",
                1);
   endtask

   // number forms, backtracking after e/p/x, and a number closed by end of text
   task automatic test_numbers();
      send_text("0 0x1F 0x 07 09 12.5e-3 1.e 1.e+ 3.E4 0x1.8p+3 0.p 0x.g 0xAbpx 7e5 5", 1);
      send_text("1.e", 1);
      send_text("1.e-", 1);
   endtask

   // strings, comments, unknown bytes and unterminated strings
   task automatic test_strings_comments();
      send_text("'a\"b' \"c'd\n\" \"\" # note\n x # tail at end", 1);
      send_byte(8'h00, 0);
      send_byte(8'h80, 0);
      send_byte(8'hFF, 0);
      send_byte(8'h0B, 0);
      send_byte(8'h0C, 0);
      send_text("\"open", 1);
   endtask

   // random token-shaped fragments with some noise bytes
   function automatic void add_text(ref logic [7:0] q[$], input string s);
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
   endfunction

   function automatic logic [7:0] rand_digit(int hi);
      return 8'("0" + $urandom_range(0, hi));
   endfunction

   function automatic void make_fragment(ref logic [7:0] q[$]);
      string ops[22] = '{"->", "-", "==", "=", "!=", "!", "<=", "<<", "<", ">=", ">>", ">",
                         "&&", "&", "||", "|", "+", "*", "(", ")", ";", "?"};
      string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
      string hexd = "0123456789abcdefABCDEF";
      int    n;
      case ($urandom_range(0, 13))
         0, 1: add_text(q, kw_text[$urandom_range(0, 14)]);
         2: begin
            n = $urandom_range(1, 9);
            q.push_back(letters[$urandom_range(0, 52)]);
            for (int i = 1; i < n; i++) q.push_back(letters[$urandom_range(0, 62)]);
         end
         3: for (int i = $urandom_range(1, 4); i > 0; i--) q.push_back(rand_digit(9));
         4: begin
            add_text(q, $urandom_range(0, 1) ? "0x" : "0X");
            for (int i = $urandom_range(0, 3); i > 0; i--)
               q.push_back(hexd[$urandom_range(0, 21)]);
            if ($urandom_range(0, 2) == 0) begin
               q.push_back(".");
               q.push_back(hexd[$urandom_range(0, 21)]);
               q.push_back($urandom_range(0, 1) ? "p" : "P");
               if ($urandom_range(0, 1)) q.push_back($urandom_range(0, 1) ? "+" : "-");
               if ($urandom_range(0, 2) != 0) q.push_back(rand_digit(9));
            end
         end
         5: for (int i = $urandom_range(1, 4); i > 0; i--) q.push_back(rand_digit(7));
         6: begin
            q.push_back(rand_digit(9));
            q.push_back(".");
            for (int i = $urandom_range(0, 2); i > 0; i--) q.push_back(rand_digit(9));
            if ($urandom_range(0, 1)) begin
               q.push_back($urandom_range(0, 1) ? "e" : "E");
               if ($urandom_range(0, 1)) q.push_back($urandom_range(0, 1) ? "+" : "-");
               if ($urandom_range(0, 2) != 0) q.push_back(rand_digit(9));
            end
         end
         7: begin
            n = $urandom_range(0, 1);
            q.push_back(n ? "'" : "\"");
            for (int i = $urandom_range(0, 5); i > 0; i--)
               q.push_back($urandom_range(0, 5) == 0 ? 8'h0A : 8'($urandom_range(32, 126)));
            if ($urandom_range(0, 5) != 0) q.push_back(n ? "'" : "\"");
         end
         8, 9: add_text(q, ops[$urandom_range(0, 21)]);
         10: q.push_back($urandom_range(0, 2) == 0 ? 8'h0A : " ");
         11: add_text(q, "# c\n");
         12: q.push_back(8'($urandom_range(0, 255)));
         default: q.push_back($urandom_range(0, 1) ? " " : 8'h09);
      endcase
      if ($urandom_range(0, 1)) q.push_back(" ");
   endfunction

   task automatic send_fragments(int count);
      logic [7:0] frag[$];
      int         sent;
      sent = 0;
      while (sent < count) begin
         frag.delete();
         make_fragment(frag);
         foreach (frag[i])
            send_byte(frag[i], i == frag.size() - 1 && $urandom_range(0, 29) == 0);
         sent += frag.size();
      end
   endtask

   task automatic test_random_text();
      send_fragments(16);
      // pause until every token has come back, then go on
      wait_drained();
      send_fragments(14);
   endtask

   // long receiver hold-off while the sender keeps offering bytes
   task automatic test_backpressure();
      stall_request = 1;
      burst_left = 100;
      send_text("while x1 == 0x1f -> ab.c 3.5e+2 'q' && y; # z\n", 1);
      wait_drained();
   endtask

   initial begin
      clear_lexer();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_words_and_operators();
      test_numbers();
      test_strings_comments();
      test_backpressure();
      test_random_text();
      wait_drained();
      $display("sent %0d bytes in %0d texts, checked %0d tokens", bytes_sent, runs_sent,
               tokens_checked);
      $display("covered keywords, operators, number backtracking, strings, comments, stalls");
      if (mismatches == 0 && expected_tokens.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #5ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/stt_pkg.sv
hw/rtl/stt_fifo.sv
hw/rtl/stt_front.sv
hw/rtl/stt_back.sv
hw/rtl/source_text_tokenizer_core.sv
dv/tb_source_text_tokenizer_core.sv
